// File: sv/round_robin_task_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrts: same-cycle check failed");
`define RRTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrts: next-cycle check failed");
`else
`define RRTS_ASSERT_IMP(label, ante, cons)
`define RRTS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: sv/rrts_pkg.sv
// Types and constants of the round-robin task scheduler.
package rrts_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SUM_W           = 48;
  localparam int DELTA_W         = 34;
  localparam int CFG_IDX_W       = 2;

  localparam logic [15:0] QUANTUM_RESET = 16'd10;
  localparam logic [15:0] ARRIVAL_RESET = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL = 2'd1;

  localparam logic MODE_ADD      = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    STAT_ADDED      = 2'd0,
    STAT_DISPATCHED = 2'd1,
    STAT_EMPTY      = 2'd2,
    STAT_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_READ  = 2'd1,
    FSM_ACCUM = 2'd2
  } fsm_t;

  // one queue slot
  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [31:0] start_time;
    logic        started;
  } entry_t;

  // update request to one running sum
  typedef struct packed {
    logic                      en;
    logic signed [DELTA_W-1:0] delta;
  } acc_upd_t;

endpackage

// File: sv/rrts_ram.sv
// Generic simple dual-port RAM with registered read.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/rrts_acc.sv
// Saturating signed 48-bit running sum.
`include "round_robin_task_scheduler_defines.svh"
module rrts_acc (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rrts_pkg::acc_upd_t                    upd,
  output logic signed [rrts_pkg::SUM_W-1:0]     sum
);

  localparam int SW = rrts_pkg::SUM_W;
  localparam int DW = rrts_pkg::DELTA_W;

  localparam logic [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [SW:0]   total;
  logic [SW-1:0] sum_next;

  always_comb begin
    total = {sum[SW-1], sum} + {{(SW+1-DW){upd.delta[DW-1]}}, upd.delta};
    if (total[SW] != total[SW-1]) begin
      sum_next = total[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = total[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (upd.en) begin
      sum <= sum_next;
    end
  end

  // non-negative sum plus non-negative delta never turns negative
  `RRTS_ASSERT_NXT(a_pos_stays_pos, upd.en && !upd.delta[DW-1] && !sum[SW-1], !sum[SW-1])
  // negative sum plus negative delta never turns non-negative
  `RRTS_ASSERT_NXT(a_neg_stays_neg, upd.en && upd.delta[DW-1] && sum[SW-1], sum[SW-1])

endmodule

// File: sv/round_robin_task_scheduler.sv
// Round-robin task scheduler with time quantum: queue memory, control and statistics.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------------
//   in      | sink      | in_valid / in_stall  | mode, burst_length
//   out     | source    | out_valid / out_stall| status .. queue_occupancy
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An add (or a dispatch on an empty queue) is taken when accepted and its word
// is registered into the output register. A dispatch runs through queue memory read,
// slice/requeue update with write-back of leftover work to the tail, then the sum
// stage (saturating sum update for a finished task), after which its word shows.
// Reset (rst, synchronous) clears pointers, count, id counter, time and sums, and
// loads a quantum of 10 and an arrival base of 0. Queue memory is not cleared.
// Stalls: a new word is taken only when the block is idle and the output register
// is empty or being drained; cfg writes are always taken (cfg_ready is tied high).
`include "round_robin_task_scheduler_defines.svh"
module round_robin_task_scheduler #(
  parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  // input words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [15:0]                    burst_length,
  // result words
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [7:0]                     task_id,
  output logic [15:0]                    slice_length,
  output logic [31:0]                    slice_start,
  output logic                           task_finished,
  output logic signed [47:0]             turnaround_sum,
  output logic signed [47:0]             waiting_sum,
  output logic signed [47:0]             response_sum,
  output logic [7:0]                     tasks_added,
  output logic [4:0]                     queue_occupancy
);

  localparam int PW = $clog2(QUEUE_DEPTH);      // queue pointer width
  localparam int CW = $clog2(QUEUE_DEPTH + 1);  // occupancy count width
  localparam int EW = $bits(rrts_pkg::entry_t);

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // control state
  rrts_pkg::fsm_t state, state_next;
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [CW-1:0]  count;
  logic [7:0]     next_id;
  logic [31:0]    cur_time;
  logic [15:0]    quantum;
  logic [15:0]    arrival;

  // per-dispatch holding registers for the accumulate cycle
  logic           fin;
  logic [31:0]    tstart;
  logic [15:0]    burst;

  // result word registers
  rrts_pkg::status_t res_status;
  logic [7:0]        res_id;
  logic [15:0]       res_slice;
  logic [31:0]       res_start;
  logic              res_finished;

  // handshakes and decode
  logic in_acc;
  logic is_add;
  logic full;
  logic empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != rrts_pkg::FSM_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign is_add    = (mode == rrts_pkg::MODE_ADD);
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  // queue memory
  logic               wr_en;
  logic [PW-1:0]      wr_addr;
  rrts_pkg::entry_t   wr_entry;
  logic               rd_en;
  logic [EW-1:0]      rd_data;
  rrts_pkg::entry_t   head_entry;

  rrts_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  assign head_entry = rrts_pkg::entry_t'(rd_data);
  assign rd_en      = in_acc && !is_add && !empty;

  // dispatch math on the entry just read
  logic [31:0] slot_start;
  logic [15:0] slice;
  logic [15:0] rem_next;
  logic [31:0] time_next;

  always_comb begin
    slot_start = head_entry.started ? head_entry.start_time : cur_time;
    slice      = (head_entry.remaining > quantum) ? quantum : head_entry.remaining;
    rem_next   = head_entry.remaining - slice;
    time_next  = cur_time + {16'd0, slice};
  end

  // tail writes: fresh task on add, leftover work on dispatch
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = tail;
    wr_entry = '0;
    if ((state == rrts_pkg::FSM_IDLE) && in_acc && is_add && !full) begin
      wr_en              = 1'b1;
      wr_entry.task_id   = next_id;
      wr_entry.burst     = burst_length;
      wr_entry.remaining = burst_length;
    end else if ((state == rrts_pkg::FSM_READ) && (rem_next != '0)) begin
      wr_en               = 1'b1;
      wr_entry.task_id    = head_entry.task_id;
      wr_entry.burst      = head_entry.burst;
      wr_entry.remaining  = rem_next;
      wr_entry.start_time = slot_start;
      wr_entry.started    = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rrts_pkg::FSM_IDLE: begin
        if (rd_en) begin
          state_next = rrts_pkg::FSM_READ;
        end
      end
      rrts_pkg::FSM_READ:  state_next = rrts_pkg::FSM_ACCUM;
      rrts_pkg::FSM_ACCUM: state_next = rrts_pkg::FSM_IDLE;
      default:             state_next = rrts_pkg::FSM_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrts_pkg::FSM_IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      next_id   <= '0;
      cur_time  <= '0;
      quantum   <= rrts_pkg::QUANTUM_RESET;
      arrival   <= rrts_pkg::ARRIVAL_RESET;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rrts_pkg::REG_QUANTUM: quantum <= cfg_data;
          rrts_pkg::REG_ARRIVAL: arrival <= cfg_data;
          default: ;
        endcase
      end

      // add, full or empty: word is ready right away; dispatch after the sum stage
      if ((state == rrts_pkg::FSM_ACCUM) ||
          ((state == rrts_pkg::FSM_IDLE) && in_acc && (is_add || empty))) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if ((state == rrts_pkg::FSM_IDLE) && in_acc) begin
        if (is_add && !full) begin
          tail    <= wrap_inc(tail);
          count   <= count + 1'b1;
          next_id <= next_id + 8'd1;
        end
      end

      if (state == rrts_pkg::FSM_READ) begin
        head     <= wrap_inc(head);
        cur_time <= time_next;
        if (rem_next == '0) begin
          count <= count - 1'b1;
        end else begin
          tail  <= wrap_inc(tail);
        end
      end
    end
  end

  // result word and holding registers (no reset needed)
  always_ff @(posedge clk) begin
    if ((state == rrts_pkg::FSM_IDLE) && in_acc) begin
      res_status   <= is_add ? (full ? rrts_pkg::STAT_FULL : rrts_pkg::STAT_ADDED)
                             : rrts_pkg::STAT_EMPTY;
      res_id       <= is_add ? next_id : 8'd0;
      res_slice    <= '0;
      res_start    <= cur_time;
      res_finished <= 1'b0;
    end else if (state == rrts_pkg::FSM_READ) begin
      res_status   <= rrts_pkg::STAT_DISPATCHED;
      res_id       <= head_entry.task_id;
      res_slice    <= slice;
      res_start    <= cur_time;
      res_finished <= (rem_next == '0);
      fin          <= (rem_next == '0);
      tstart       <= slot_start;
      burst        <= head_entry.burst;
    end
  end

  // statistics: deltas from registered time, then saturating adds
  logic [16:0]        arr_burst;
  rrts_pkg::acc_upd_t upd_turn;
  rrts_pkg::acc_upd_t upd_wait;
  rrts_pkg::acc_upd_t upd_resp;
  logic               acc_en;

  assign acc_en    = (state == rrts_pkg::FSM_ACCUM) && fin;
  assign arr_burst = {1'b0, arrival} + {1'b0, burst};

  always_comb begin
    upd_turn.en    = acc_en;
    upd_turn.delta = $signed({2'b00, cur_time}) - $signed({18'd0, arrival});
    upd_wait.en    = acc_en;
    upd_wait.delta = $signed({2'b00, cur_time}) - $signed({17'd0, arr_burst});
    upd_resp.en    = acc_en;
    upd_resp.delta = $signed({2'b00, tstart}) - $signed({18'd0, arrival});
  end

  rrts_acc u_turn (.clk(clk), .rst(rst), .upd(upd_turn), .sum(turnaround_sum));
  rrts_acc u_wait (.clk(clk), .rst(rst), .upd(upd_wait), .sum(waiting_sum));
  rrts_acc u_resp (.clk(clk), .rst(rst), .upd(upd_resp), .sum(response_sum));

  // outputs
  logic [CW+4:0] count_ext;
  assign count_ext       = {5'd0, count};
  assign status          = res_status;
  assign task_id         = res_id;
  assign slice_length    = res_slice;
  assign slice_start     = res_start;
  assign task_finished   = res_finished;
  assign tasks_added     = next_id;
  assign queue_occupancy = count_ext[4:0];

  // pointer bookkeeping check: tail sits count slots after head
  logic [PW:0] ht_sum;
  logic [PW:0] ht_wrap;
  always_comb begin
    ht_sum  = {1'b0, head} + (PW+1)'(count);
    ht_wrap = (ht_sum >= (PW+1)'(QUEUE_DEPTH)) ? ht_sum - (PW+1)'(QUEUE_DEPTH) : ht_sum;
  end

  `RRTS_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(QUEUE_DEPTH))
  `RRTS_ASSERT_IMP(a_ptr_consistent, state == rrts_pkg::FSM_IDLE, tail == ht_wrap[PW-1:0])
  `RRTS_ASSERT_IMP(a_no_rw_same_cycle, rd_en, !wr_en || (wr_addr != head) || full)
  `RRTS_ASSERT_NXT(a_read_then_update, rd_en, state == rrts_pkg::FSM_READ)
  `RRTS_ASSERT_NXT(a_accum_sets_valid, state == rrts_pkg::FSM_ACCUM, out_valid)

endmodule
